// ===== design/fwip_pkg.sv =====
// Shared types, widths and codes of the four-wheel incremental PID controller
package fwip_pkg;

   // field widths of the input and result items
   localparam int COUNT_W  = 16;
   localparam int SPEED_W  = 8;
   localparam int STEER_W  = 11;
   localparam int DUTY_W   = 10;
   localparam int DIFF_W   = 17;

   // configuration port
   localparam int GAIN_W      = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_I      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_D      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_MODE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_EXT     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACC_ENABLE  = 3'd5;

   localparam logic [GAIN_W-1:0] GAIN_P_RESET = 12'd152;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = 12'd160;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = 12'd32;

   typedef enum logic [1:0] {
      MODE_FORWARD,
      MODE_REVERSE,
      MODE_SPIN_LEFT,
      MODE_SPIN_RIGHT
   } drive_mode_type;

   // internal arithmetic widths
   localparam int SAMPLE_W = COUNT_W + 1;
   localparam int TARGET_W = SPEED_W + 1;
   localparam int DRIVE_W  = 11;
   localparam int ERR_W    = 18;
   localparam int DE_W     = ERR_W + 1;
   localparam int DD_W     = ERR_W + 2;
   localparam int PROD_W   = DD_W + GAIN_W + 1;
   localparam int ACC_W    = PROD_W + 2;
   localparam int CPROD_W  = DIFF_W + 9;
   localparam int CORR_W   = 15;

   // encoder correction: 0.1 as 205 / 2048, floor by 16 then truncate by 128
   localparam logic signed [CPROD_W-1:0] CORR_NUM   = 26'sd205;
   localparam logic signed [CPROD_W-1:0] TRUNC_BIAS = 26'sd127;

   // wheels
   localparam int NUM_WHEELS = 4;
   localparam int WIDX_W     = 2;
   localparam logic [WIDX_W-1:0] WHEEL_FL = 2'd0;
   localparam logic [WIDX_W-1:0] WHEEL_FR = 2'd1;
   localparam logic [WIDX_W-1:0] WHEEL_BL = 2'd2;
   localparam logic [WIDX_W-1:0] WHEEL_BR = 2'd3;

   // stream packing
   localparam int REQ_DATA_W    = 88;
   localparam int REQ_FL_LSB    = 0;
   localparam int REQ_FR_LSB    = 16;
   localparam int REQ_BL_LSB    = 32;
   localparam int REQ_BR_LSB    = 48;
   localparam int REQ_SPEED_LSB = 64;
   localparam int REQ_STEER_LSB = 72;
   localparam int REQ_CLEAR_BIT = 83;

   localparam int RSP_DATA_W   = 64;
   localparam int RSP_FIELDS_W = 61;
   localparam int RSP_WHEEL_W  = DUTY_W + 1;
   localparam int RSP_DIFF_LSB = NUM_WHEELS * RSP_WHEEL_W;

   // result queue
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   // per-wheel state word kept in the state memory
   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic signed [ERR_W-1:0]   prev;
      logic signed [ERR_W-1:0]   older;
   } wheel_state_type;

   // item held while its wheels are issued
   typedef struct packed {
      logic signed [COUNT_W-1:0] cnt_fl;
      logic signed [COUNT_W-1:0] cnt_fr;
      logic signed [COUNT_W-1:0] cnt_bl;
      logic signed [COUNT_W-1:0] cnt_br;
      logic [SPEED_W-1:0]        speed;
      logic signed [STEER_W-1:0] steer;
      logic signed [DIFF_W-1:0]  diff;
   } item_type;

   // pipeline stage payloads
   typedef struct packed {
      logic [WIDX_W-1:0]          idx;
      logic                       last;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [TARGET_W-1:0] target;
      logic signed [DIFF_W-1:0]   diff;
      logic signed [STEER_W-1:0]  steer;
   } stage1_type;

   typedef struct packed {
      logic [WIDX_W-1:0]         idx;
      logic                      last;
      logic signed [DIFF_W-1:0]  diff;
      logic signed [STEER_W-1:0] steer;
      logic signed [ERR_W-1:0]   e;
      logic signed [ERR_W-1:0]   e1;
      logic signed [DE_W-1:0]    de;
      logic signed [DD_W-1:0]    dd;
      logic signed [DRIVE_W-1:0] drive;
   } stage2_type;

   typedef struct packed {
      logic [WIDX_W-1:0]          idx;
      logic                       last;
      logic signed [DIFF_W-1:0]   diff;
      logic signed [STEER_W-1:0]  steer;
      logic signed [ERR_W-1:0]    e;
      logic signed [ERR_W-1:0]    e1;
      logic signed [DRIVE_W-1:0]  drive;
      logic signed [PROD_W-1:0]   pp;
      logic signed [PROD_W-1:0]   pi;
      logic signed [PROD_W-1:0]   pd;
      logic signed [CPROD_W-1:0]  cprod;
   } stage3_type;

   typedef struct packed {
      logic [WIDX_W-1:0]         idx;
      logic                      last;
      logic signed [DIFF_W-1:0]  diff;
      logic signed [ERR_W-1:0]   e;
      logic signed [ERR_W-1:0]   e1;
      logic signed [DRIVE_W-1:0] d830;
      logic signed [CORR_W-1:0]  corr;
   } stage4_type;

   // front-left and back-left take the correction with a minus sign
   function automatic logic is_left(input logic [WIDX_W-1:0] idx);
      return (idx == WHEEL_FL) || (idx == WHEEL_BL);
   endfunction

endpackage

// ===== design/fwip_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data
module fwip_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== design/four_wheel_incremental_pid.sv =====
// Top level of the four-wheel incremental PID velocity controller
//
// One req item is one control tick: four raw encoder counts, a target speed,
// a steering correction and a sum-clear flag. One rsp item comes back per
// tick with duty and direction for each wheel and the encoder-sum difference.
// Gains, drive mode and the two mode flags are written on the csr channel,
// which is always ready; write it only while no tick is in flight.
// The wheels share one PID pipeline and one state memory (drive and last
// two errors per wheel, one read and one write port). Wheels are issued one
// per cycle unless one must wait, for min(WHEEL_COUNT, 4) active wheels, and
// a new tick can be accepted in the cycle that its last wheel is issued; with
// one or two wheels a wheel waits while its previous update is in stage 1 or 2.
// Reset restores the register defaults, clears the encoder sums and marks
// every state entry invalid, so it reads as zero until written; no clearing
// pass is needed. Up to four results queue behind rsp; when four ticks are
// outstanding req_tready drops until rsp_tready takes one.
module four_wheel_incremental_pid
   import fwip_pkg::*;
#(
   parameter int PID_LIMIT   = 830,
   parameter int OUT_LIMIT   = 850,
   parameter int WHEEL_COUNT = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   // req_tdata from bit 0: count_front_left, count_front_right, count_back_left,
   // count_back_right, target_speed, steer_correction, clear_sums, zero pad
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // rsp_tdata from bit 0: duty_front_left, dir_front_left, duty_front_right,
   // dir_front_right, duty_back_left, dir_back_left, duty_back_right,
   // dir_back_right, sum_difference, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int ACTIVE = (WHEEL_COUNT < NUM_WHEELS) ? WHEEL_COUNT : NUM_WHEELS;
   localparam int ADDR_W = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
   localparam int STATE_W = $bits(wheel_state_type);
   localparam logic [WIDX_W-1:0] LAST_WHEEL = WIDX_W'(ACTIVE - 1);
   localparam logic signed [DRIVE_W-1:0] PID_POS = DRIVE_W'(PID_LIMIT);
   localparam logic signed [DRIVE_W-1:0] PID_NEG = -PID_POS;
   localparam logic signed [DRIVE_W-1:0] OUT_POS = DRIVE_W'(OUT_LIMIT);
   localparam logic signed [DRIVE_W-1:0] OUT_NEG = -OUT_POS;

   // configuration registers
   logic [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   drive_mode_type    mode_ff;
   logic              use_ext_ff, acc_en_ff;

   // tick-level state and control
   logic signed [COUNT_W-1:0] sum_f_ff, sum_f_in, sum_b_ff, sum_b_in;
   item_type                  item_ff, item_in;
   logic                      busy_ff, busy_in;
   logic [WIDX_W-1:0]         widx_ff, widx_in;
   logic [RSP_CNT_W-1:0]      credit_ff, credit_in;
   logic                      req_fire, issue, issue_last, hazard;

   // pipeline
   logic            s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   stage1_type      s1_ff, s1_in;
   stage2_type      s2_ff, s2_in;
   stage3_type      s3_ff, s3_in;
   stage4_type      s4_ff, s4_in;

   // state memory and forwarding
   logic [ACTIVE-1:0]  wvalid_ff;
   logic               rd_valid_ff;
   logic [STATE_W-1:0] ram_rd_data;
   wheel_state_type    ram_state, cur_state, wr_state;
   logic               hold_valid_ff;
   logic [WIDX_W-1:0]  hold_idx_ff;
   wheel_state_type    hold_state_ff;

   // result assembly and queue
   logic signed [DRIVE_W-1:0] drive_out;
   logic [DUTY_W-1:0]         duty_out;
   logic                      dir_out;
   logic [DUTY_W-1:0]         asm_duty_ff [NUM_WHEELS];
   logic                      asm_dir_ff  [NUM_WHEELS];
   logic [RSP_FIELDS_W-1:0]   result;
   logic                      push, pop;
   logic [RSP_FIELDS_W-1:0]   rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0]      fill_ff, fill_in;

   // configuration writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff  <= GAIN_P_RESET;
         gain_i_ff  <= GAIN_I_RESET;
         gain_d_ff  <= GAIN_D_RESET;
         mode_ff    <= MODE_FORWARD;
         use_ext_ff <= 1'b1;
         acc_en_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_GAIN_P:     gain_p_ff  <= csr_data;
            CSR_GAIN_I:     gain_i_ff  <= csr_data;
            CSR_GAIN_D:     gain_d_ff  <= csr_data;
            CSR_DRIVE_MODE: mode_ff    <= drive_mode_type'(csr_data[1:0]);
            CSR_USE_EXT:    use_ext_ff <= csr_data[0];
            CSR_ACC_ENABLE: acc_en_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // acceptance: one tick is held while its wheels go out
   assign req_tready = (!busy_ff || issue_last) && (credit_ff < RSP_CNT_W'(RSP_DEPTH));
   assign req_fire   = req_tvalid && req_tready;

   // encoder sums, clear then accumulate when enabled, and their magnitude difference
   always_comb begin
      logic signed [COUNT_W-1:0] base_f, base_b;
      logic [COUNT_W-1:0]        mag_f, mag_b;
      base_f = req_tdata[REQ_CLEAR_BIT] ? '0 : sum_f_ff;
      base_b = req_tdata[REQ_CLEAR_BIT] ? '0 : sum_b_ff;
      sum_f_in = base_f;
      sum_b_in = base_b;
      if (acc_en_ff) begin
         sum_f_in = base_f - $signed(req_tdata[REQ_FL_LSB +: COUNT_W]);
         sum_b_in = base_b - $signed(req_tdata[REQ_BL_LSB +: COUNT_W]);
      end
      mag_f = sum_f_in[COUNT_W-1] ? (~sum_f_in + 1'b1) : sum_f_in;
      mag_b = sum_b_in[COUNT_W-1] ? (~sum_b_in + 1'b1) : sum_b_in;
      item_in.cnt_fl = $signed(req_tdata[REQ_FL_LSB +: COUNT_W]);
      item_in.cnt_fr = $signed(req_tdata[REQ_FR_LSB +: COUNT_W]);
      item_in.cnt_bl = $signed(req_tdata[REQ_BL_LSB +: COUNT_W]);
      item_in.cnt_br = $signed(req_tdata[REQ_BR_LSB +: COUNT_W]);
      item_in.speed  = req_tdata[REQ_SPEED_LSB +: SPEED_W];
      item_in.steer  = $signed(req_tdata[REQ_STEER_LSB +: STEER_W]);
      item_in.diff   = $signed({1'b0, mag_f} - {1'b0, mag_b});
   end

   // wheel sequencer; a wheel waits while its last update is in stage 1 or 2
   assign hazard = (s1_valid_ff && (s1_ff.idx == widx_ff)) ||
                   (s2_valid_ff && (s2_ff.idx == widx_ff));
   assign issue      = busy_ff && !hazard;
   assign issue_last = issue && (widx_ff == LAST_WHEEL);

   always_comb begin
      busy_in = busy_ff;
      widx_in = widx_ff;
      if (issue) begin
         widx_in = issue_last ? '0 : widx_ff + 1'b1;
      end
      if (req_fire) begin
         busy_in = 1'b1;
      end else if (issue_last) begin
         busy_in = 1'b0;
      end
   end

   assign credit_in = credit_ff + RSP_CNT_W'(req_fire) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         widx_ff   <= '0;
         credit_ff <= '0;
         sum_f_ff  <= '0;
         sum_b_ff  <= '0;
      end else begin
         busy_ff   <= busy_in;
         widx_ff   <= widx_in;
         credit_ff <= credit_in;
         if (req_fire) begin
            sum_f_ff <= sum_f_in;
            sum_b_ff <= sum_b_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= item_in;
      end
   end

   // issue stage: speed sample and signed target of the selected wheel
   always_comb begin
      logic signed [COUNT_W-1:0]  cnt;
      logic signed [SAMPLE_W-1:0] cnt_ext;
      logic signed [TARGET_W-1:0] spd;
      logic                       neg_t;
      case (widx_ff)
         WHEEL_FL: cnt = item_ff.cnt_fl;
         WHEEL_FR: cnt = item_ff.cnt_fr;
         WHEEL_BL: cnt = item_ff.cnt_bl;
         default:  cnt = item_ff.cnt_br;
      endcase
      cnt_ext = SAMPLE_W'(cnt);
      spd     = $signed({1'b0, item_ff.speed});
      case (mode_ff)
         MODE_FORWARD:    neg_t = 1'b0;
         MODE_REVERSE:    neg_t = 1'b1;
         MODE_SPIN_LEFT:  neg_t = is_left(widx_ff);
         MODE_SPIN_RIGHT: neg_t = !is_left(widx_ff);
         default:         neg_t = 1'b0;
      endcase
      s1_in.idx    = widx_ff;
      s1_in.last   = (widx_ff == LAST_WHEEL);
      s1_in.sample = (widx_ff == WHEEL_FR) ? cnt_ext : -cnt_ext;
      s1_in.target = neg_t ? -spd : spd;
      s1_in.diff   = item_ff.diff;
      s1_in.steer  = item_ff.steer;
   end

   // state memory: drive and the last two errors of each wheel
   fwip_ram #(
      .WIDTH (STATE_W),
      .DEPTH (ACTIVE)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s4_valid_ff),
      .wr_addr (s4_ff.idx[ADDR_W-1:0]),
      .wr_data (wr_state),
      .rd_en   (issue),
      .rd_addr (widx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   assign ram_state = wheel_state_type'(ram_rd_data);

   // entry valid bits; an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         wvalid_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         if (s4_valid_ff) begin
            wvalid_ff[s4_ff.idx[ADDR_W-1:0]] <= 1'b1;
         end
         if (issue) begin
            rd_valid_ff <= wvalid_ff[widx_ff[ADDR_W-1:0]];
         end
         hold_valid_ff <= s4_valid_ff;
      end
   end

   // last write, for a read that was captured at the same edge
   always_ff @(posedge clock) begin
      hold_idx_ff   <= s4_ff.idx;
      hold_state_ff <= wr_state;
   end

   // stage 1: forwarding and error terms
   always_comb begin
      logic signed [ERR_W-1:0] e;
      if (s4_valid_ff && (s4_ff.idx == s1_ff.idx)) begin
         cur_state = wr_state;
      end else if (hold_valid_ff && (hold_idx_ff == s1_ff.idx)) begin
         cur_state = hold_state_ff;
      end else if (rd_valid_ff) begin
         cur_state = ram_state;
      end else begin
         cur_state = '0;
      end
      e = ERR_W'(s1_ff.target) - ERR_W'(s1_ff.sample);
      s2_in.idx   = s1_ff.idx;
      s2_in.last  = s1_ff.last;
      s2_in.diff  = s1_ff.diff;
      s2_in.steer = s1_ff.steer;
      s2_in.e     = e;
      s2_in.e1    = cur_state.prev;
      s2_in.de    = DE_W'(e) - DE_W'(cur_state.prev);
      s2_in.dd    = DD_W'(e) - (DD_W'(cur_state.prev) <<< 1) + DD_W'(cur_state.older);
      s2_in.drive = cur_state.drive;
   end

   // stage 2: gain products and the correction product
   always_comb begin
      s3_in.idx   = s2_ff.idx;
      s3_in.last  = s2_ff.last;
      s3_in.diff  = s2_ff.diff;
      s3_in.steer = s2_ff.steer;
      s3_in.e     = s2_ff.e;
      s3_in.e1    = s2_ff.e1;
      s3_in.drive = s2_ff.drive;
      s3_in.pp    = PROD_W'($signed({1'b0, gain_p_ff})) * PROD_W'(s2_ff.de);
      s3_in.pi    = PROD_W'($signed({1'b0, gain_i_ff})) * PROD_W'(s2_ff.e);
      s3_in.pd    = PROD_W'($signed({1'b0, gain_d_ff})) * PROD_W'(s2_ff.dd);
      s3_in.cprod = CPROD_W'(s2_ff.diff) * CORR_NUM;
   end

   // stage 3: increment, first saturation and correction select
   always_comb begin
      logic signed [ACC_W-1:0]   acc;
      logic signed [ACC_W:0]     tot;
      logic signed [CPROD_W-1:0] q;
      logic signed [CPROD_W-1:0] qt;
      logic signed [CORR_W-1:0]  enc_corr;
      acc = ACC_W'(s3_ff.pp) + ACC_W'(s3_ff.pi) + ACC_W'(s3_ff.pd);
      tot = (ACC_W+1)'(acc >>> 4) + (ACC_W+1)'(s3_ff.drive);
      q   = s3_ff.cprod >>> 4;
      qt  = q[CPROD_W-1] ? ((q + TRUNC_BIAS) >>> 7) : (q >>> 7);
      enc_corr = qt[CORR_W-1:0];
      s4_in.idx  = s3_ff.idx;
      s4_in.last = s3_ff.last;
      s4_in.diff = s3_ff.diff;
      s4_in.e    = s3_ff.e;
      s4_in.e1   = s3_ff.e1;
      if (tot > (ACC_W+1)'(PID_POS)) begin
         s4_in.d830 = PID_POS;
      end else if (tot < (ACC_W+1)'(PID_NEG)) begin
         s4_in.d830 = PID_NEG;
      end else begin
         s4_in.d830 = tot[DRIVE_W-1:0];
      end
      s4_in.corr = '0;
      if (mode_ff inside {MODE_FORWARD, MODE_REVERSE}) begin
         s4_in.corr = use_ext_ff ? CORR_W'(s3_ff.steer) : enc_corr;
      end
   end

   // stage 4: correction, final saturation, write-back and duty
   always_comb begin
      logic signed [CORR_W:0]     t;
      logic signed [DRIVE_W-1:0]  mag;
      if (is_left(s4_ff.idx)) begin
         t = (CORR_W+1)'(s4_ff.d830) - (CORR_W+1)'(s4_ff.corr);
      end else begin
         t = (CORR_W+1)'(s4_ff.d830) + (CORR_W+1)'(s4_ff.corr);
      end
      if (t > (CORR_W+1)'(OUT_POS)) begin
         drive_out = OUT_POS;
      end else if (t < (CORR_W+1)'(OUT_NEG)) begin
         drive_out = OUT_NEG;
      end else begin
         drive_out = t[DRIVE_W-1:0];
      end
      wr_state.drive = drive_out;
      wr_state.prev  = s4_ff.e;
      wr_state.older = s4_ff.e1;
      mag      = drive_out[DRIVE_W-1] ? -drive_out : drive_out;
      duty_out = mag[DUTY_W-1:0];
      dir_out  = is_left(s4_ff.idx) ? !drive_out[DRIVE_W-1] : drive_out[DRIVE_W-1];
   end

   // pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
   end

   // per-wheel result collection
   always_ff @(posedge clock) begin
      if (s4_valid_ff) begin
         asm_duty_ff[s4_ff.idx] <= duty_out;
         asm_dir_ff[s4_ff.idx]  <= dir_out;
      end
   end

   // full result on the last wheel; wheels not fitted report a zero drive
   always_comb begin
      result = '0;
      for (int w = 0; w < NUM_WHEELS; w++) begin
         if (WIDX_W'(w) == s4_ff.idx) begin
            result[w*RSP_WHEEL_W +: DUTY_W]    = duty_out;
            result[w*RSP_WHEEL_W + DUTY_W]     = dir_out;
         end else if (w < ACTIVE) begin
            result[w*RSP_WHEEL_W +: DUTY_W]    = asm_duty_ff[w];
            result[w*RSP_WHEEL_W + DUTY_W]     = asm_dir_ff[w];
         end else begin
            result[w*RSP_WHEEL_W +: DUTY_W]    = '0;
            result[w*RSP_WHEEL_W + DUTY_W]     = is_left(WIDX_W'(w));
         end
      end
      result[RSP_DIFF_LSB +: DIFF_W] = s4_ff.diff;
   end

   // result queue
   assign push       = s4_valid_ff && s4_ff.last;
   assign rsp_tvalid = (fill_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign fill_in    = fill_ff + RSP_CNT_W'(push) - RSP_CNT_W'(pop);
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_FIELDS_W){1'b0}}, rsp_mem_ff[rd_ptr_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         fill_ff <= fill_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_mem_ff[wr_ptr_ff] <= result;
      end
   end

   // outstanding ticks bound the queue
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("outstanding item count above queue depth");

   a_fill_credit: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= credit_ff)
      else $error("queued results exceed outstanding items");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (fill_ff != RSP_CNT_W'(RSP_DEPTH)))
      else $error("result pushed into a full queue");

   a_drive_limit: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff |-> ((drive_out <= OUT_POS) && (drive_out >= OUT_NEG)))
      else $error("written drive outside output limit");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (busy_ff && (widx_ff == '0)))
      else $error("accepted item did not start at the first wheel");

endmodule
